/* rtl/core/exti_pkg.sv */
`timescale 1ns / 1ps

package exti_pkg;

    // Fixed geometry of the register map and the pin bus.
    localparam int MAX_LINES  = 16;
    localparam int SEL_W      = 4;
    localparam int PORT_PINS  = 16;
    localparam int PIN_W      = 64;
    localparam int CHOICE_W   = MAX_LINES * SEL_W;
    localparam int IRQ_W      = 7;

    // Operation codes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register select codes. Codes from REG_GROUP0 upward address port-select groups.
    localparam logic [2:0] REG_MASK    = 3'd0;
    localparam logic [2:0] REG_RISE    = 3'd1;
    localparam logic [2:0] REG_FALL    = 3'd2;
    localparam logic [2:0] REG_PEND    = 3'd3;
    localparam logic [2:0] REG_GROUP0  = 3'd4;

    typedef struct packed {
        logic [1:0]       operation;
        logic [2:0]       reg_select;
        logic [15:0]      write_data;
        logic [PIN_W-1:0] pin_levels;
    } cmd_word_t;

    typedef struct packed {
        logic [15:0]      read_data;
        logic [15:0]      pending_lines;
        logic [IRQ_W-1:0] irq_lines;
    } rsp_word_t;

endpackage

/* rtl/core/exti_line_mux.sv */
`timescale 1ns / 1ps

// Routes each line's level from the port picked by its selector. A selector
// that names no existing port gives level zero.
module exti_line_mux
    import exti_pkg::*;
#(
    parameter int NUM_PORTS = 4
)
(
    input  logic [PIN_W-1:0]     pin_levels,
    input  logic [CHOICE_W-1:0]  choice_flat,
    output logic [MAX_LINES-1:0] levels
);

    always_comb
    begin
        logic [SEL_W-1:0] port;
        levels = '0;
        for (int i = 0; i < MAX_LINES; i++)
        begin
            port = choice_flat[i*SEL_W +: SEL_W];
            if (port < SEL_W'(NUM_PORTS))
            begin
                levels[i] = pin_levels[{port[1:0], 4'(i)}];
            end
        end
    end

endmodule

/* rtl/core/exti_regfile.sv */
`timescale 1ns / 1ps

// Holds the controller state and executes one command word per enabled
// cycle, producing the matching response word.
module exti_regfile
    import exti_pkg::*;
#(
    parameter int NUM_PORTS = 4,
    parameter int NUM_LINES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      exec,
    input  cmd_word_t cmd,
    output rsp_word_t rsp
);

    localparam logic [MAX_LINES-1:0] LINE_BITS = MAX_LINES'((32'd1 << NUM_LINES) - 32'd1);

    logic [MAX_LINES-1:0] mask_reg, mask_next;
    logic [MAX_LINES-1:0] rise_en_reg, rise_en_next;
    logic [MAX_LINES-1:0] fall_en_reg, fall_en_next;
    logic [MAX_LINES-1:0] pend_reg, pend_next;
    logic [MAX_LINES-1:0] last_lvl_reg, last_lvl_next;
    logic [SEL_W-1:0]     choice_reg  [NUM_LINES];
    logic [SEL_W-1:0]     choice_next [NUM_LINES];

    logic [CHOICE_W-1:0]  choice_flat;
    logic [MAX_LINES-1:0] levels;
    logic [MAX_LINES-1:0] lv;
    logic [MAX_LINES-1:0] masked;
    logic [15:0]          read_data;

    // Lines that do not exist read back as port zero.
    for (genvar i = 0; i < MAX_LINES; i++)
    begin : g_flat
        if (i < NUM_LINES)
        begin : g_live
            assign choice_flat[i*SEL_W +: SEL_W] = choice_reg[i];
        end
        else
        begin : g_dead
            assign choice_flat[i*SEL_W +: SEL_W] = '0;
        end
    end

    exti_line_mux #(
        .NUM_PORTS (NUM_PORTS)
    ) u_line_mux (
        .pin_levels  (cmd.pin_levels),
        .choice_flat (choice_flat),
        .levels      (levels)
    );

    assign lv = levels & LINE_BITS;

    always_comb
    begin
        mask_next     = mask_reg;
        rise_en_next  = rise_en_reg;
        fall_en_next  = fall_en_reg;
        pend_next     = pend_reg;
        last_lvl_next = last_lvl_reg;
        choice_next   = choice_reg;
        read_data     = '0;

        case (cmd.operation)
            OP_TICK:
            begin
                // Both edge kinds compare against the level seen at the previous tick.
                pend_next = pend_reg | (((lv & ~last_lvl_reg & rise_en_reg)
                                       | (~lv & last_lvl_reg & fall_en_reg)) & LINE_BITS);
                last_lvl_next = lv;
            end
            OP_READ:
            begin
                case (cmd.reg_select)
                    REG_MASK: read_data = mask_reg;
                    REG_RISE: read_data = rise_en_reg;
                    REG_FALL: read_data = fall_en_reg;
                    REG_PEND: read_data = pend_reg;
                    default:  read_data = choice_flat[{cmd.reg_select[1:0], 4'd0} +: 16];
                endcase
            end
            OP_WRITE:
            begin
                case (cmd.reg_select)
                    REG_MASK: mask_next    = cmd.write_data & LINE_BITS;
                    REG_RISE: rise_en_next = cmd.write_data & LINE_BITS;
                    REG_FALL: fall_en_next = cmd.write_data & LINE_BITS;
                    REG_PEND: pend_next    = pend_reg & ~cmd.write_data & LINE_BITS;
                    default:
                    begin
                        for (int i = 0; i < NUM_LINES; i++)
                        begin
                            if (2'(i / 4) == cmd.reg_select[1:0])
                            begin
                                choice_next[i] = cmd.write_data[(i % 4)*SEL_W +: SEL_W];
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                read_data = '0;
            end
        endcase
    end

    assign masked = pend_next & mask_next & LINE_BITS;

    always_comb
    begin
        rsp.read_data     = read_data;
        rsp.pending_lines = pend_next;
        rsp.irq_lines     = {|masked[15:10], |masked[9:5], masked[4:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            rise_en_reg  <= '0;
            fall_en_reg  <= '0;
            pend_reg     <= '0;
            last_lvl_reg <= '0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                choice_reg[i] <= '0;
            end
        end
        else if (exec)
        begin
            mask_reg     <= mask_next;
            rise_en_reg  <= rise_en_next;
            fall_en_reg  <= fall_en_next;
            pend_reg     <= pend_next;
            last_lvl_reg <= last_lvl_next;
            choice_reg   <= choice_next;
        end
    end

endmodule

/* rtl/core/external_interrupt_edge_controller_unit.sv */
`timescale 1ns / 1ps

// External interrupt edge controller with up to sixteen lines.
// The command channel (cmd_valid, cmd_stall, cmd) carries one word per item:
// a pin sample tick with the levels of all GPIO ports, a register read, or a
// register write. Every command word yields exactly one response word on the
// response channel (rsp_valid, rsp_stall, rsp) holding the read data, the
// pending flags after the command, and the seven grouped interrupt lines.
// A command word is registered in the command register at the edge where it
// is accepted, executed against the register state once the response
// register is free or drains, and its response is registered in the response
// register at the edge where it executes. The execute step is narrow logic,
// so while the receiver does not hold rsp_stall a new command word is taken
// every cycle and throughput is one word per cycle.
// When the receiver holds rsp_stall, the response register keeps its word,
// the command register fills, and cmd_stall rises until the response drains.
// Reset clears all registers but the payload registers: every line masked, no
// edge enabled, nothing pending, all lines on port zero, and both channels empty.
module external_interrupt_edge_controller_unit
    import exti_pkg::*;
#(
    parameter int NUM_PORTS = 4,
    parameter int NUM_LINES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    cmd_word_t cmd_reg;
    logic      cmd_vld_reg, cmd_vld_next;
    rsp_word_t rsp_reg;
    logic      rsp_vld_reg, rsp_vld_next;
    rsp_word_t rsp_result;
    logic      accept;
    logic      advance;

    // The held command executes when the response register is free or drains now.
    assign advance   = cmd_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign cmd_stall = cmd_vld_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        cmd_vld_next = cmd_vld_reg;
        if (accept)
        begin
            cmd_vld_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_vld_next = 1'b0;
        end

        rsp_vld_next = rsp_vld_reg;
        if (advance)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp_vld_reg && !rsp_stall)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    exti_regfile #(
        .NUM_PORTS (NUM_PORTS),
        .NUM_LINES (NUM_LINES)
    ) u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .exec  (advance),
        .cmd   (cmd_reg),
        .rsp   (rsp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            cmd_vld_reg <= cmd_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            rsp_reg <= rsp_result;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

/* sim/external_interrupt_edge_controller_unit_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the external interrupt edge controller.
// Command words go out through a clocked driver that pulls from a backlog
// queue filled up front by the stimulus block. Every accepted word is also run
// through a local model of the register file and edge logic, and the response
// that the block owes for it is queued. A clocked monitor compares each
// accepted response word with the oldest queued one, field by field.
module external_interrupt_edge_controller_unit_tb;
    import exti_pkg::*;

    localparam int NUM_PORTS = 4;
    localparam int NUM_LINES = 16;

    // The package names three operations; the fourth code must do nothing.
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int DIRECTED_WORDS = 25;
    localparam int RANDOM_WORDS   = 825;
    localparam int IDLE_PCT       = 7;
    localparam int QUIET_FROM     = 300;
    localparam int QUIET_TO       = 600;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    cmd_word_t cmd_backlog_q[$];
    rsp_word_t rsp_expected_q[$];
    rsp_word_t rsp_want;

    // Model copy of the block's registers.
    logic [15:0] mask_bits;
    logic [15:0] rise_en_bits;
    logic [15:0] fall_en_bits;
    logic [15:0] pend_bits;
    logic [15:0] last_level;
    logic [3:0]  line_port[MAX_LINES];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  silent_cycles = 0;
    bit  quiet;

    external_interrupt_edge_controller_unit #(
        .NUM_PORTS(NUM_PORTS),
        .NUM_LINES(NUM_LINES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // No idling on either side inside this window of cycles.
    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    // Applies one command word to the model registers and returns the response
    // word the block must produce for it.
    function automatic rsp_word_t exti_execute(cmd_word_t c);
        logic [15:0] levels;
        logic [15:0] rises;
        logic [15:0] falls;
        logic [15:0] live;
        rsp_word_t   r;
        int          grp;
        r = '0;
        grp = int'(c.reg_select) - int'(REG_GROUP0);
        case (c.operation)
            OP_TICK:
            begin
                // A line whose selector names no existing port sees a low level.
                levels = '0;
                for (int i = 0; i < MAX_LINES; i++)
                begin
                    if (int'(line_port[i]) < NUM_PORTS)
                        levels[i] = c.pin_levels[int'(line_port[i]) * PORT_PINS + i];
                end
                // Both edge kinds compare against the level of the previous tick.
                rises = levels & ~last_level;
                falls = ~levels & last_level;
                pend_bits = pend_bits | (rises & rise_en_bits) | (falls & fall_en_bits);
                last_level = levels;
            end
            OP_READ:
            begin
                case (c.reg_select)
                    REG_MASK: r.read_data = mask_bits;
                    REG_RISE: r.read_data = rise_en_bits;
                    REG_FALL: r.read_data = fall_en_bits;
                    REG_PEND: r.read_data = pend_bits;
                    default:
                    begin
                        for (int k = 0; k < 4; k++)
                            r.read_data[4*k +: 4] = line_port[4*grp + k];
                    end
                endcase
            end
            OP_WRITE:
            begin
                case (c.reg_select)
                    REG_MASK: mask_bits = c.write_data;
                    REG_RISE: rise_en_bits = c.write_data;
                    REG_FALL: fall_en_bits = c.write_data;
                    // Ones clear pending flags, zeros leave them alone.
                    REG_PEND: pend_bits = pend_bits & ~c.write_data;
                    default:
                    begin
                        for (int k = 0; k < 4; k++)
                            line_port[4*grp + k] = c.write_data[4*k +: 4];
                    end
                endcase
            end
            default:
            begin
                // The unused operation code changes nothing.
            end
        endcase
        live = pend_bits & mask_bits;
        r.pending_lines = pend_bits;
        r.irq_lines = {|live[15:10], |live[9:5], live[4:0]};
        return r;
    endfunction

    function automatic logic [63:0] random_pins();
        return {$urandom(), $urandom()};
    endfunction

    // Port selectors mostly name real ports so that lines see live pins; now
    // and then a selector names no port at all.
    function automatic logic [15:0] random_group();
        logic [15:0] v;
        for (int k = 0; k < 4; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                v[4*k +: 4] = 4'($urandom_range(NUM_PORTS, 15));
            else
                v[4*k +: 4] = 4'($urandom_range(0, NUM_PORTS - 1));
        end
        return v;
    endfunction

    task automatic push_word(logic [1:0] op, logic [2:0] sel, logic [15:0] data,
                             logic [63:0] pins);
        cmd_word_t c;
        c.operation  = op;
        c.reg_select = sel;
        c.write_data = data;
        c.pin_levels = pins;
        cmd_backlog_q.push_back(c);
    endtask

    // Ticks carry random register fields since the block must ignore them.
    task automatic push_tick(logic [63:0] pins);
        push_word(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom()), pins);
    endtask

    task automatic push_read(logic [2:0] sel);
        push_word(OP_READ, sel, 16'($urandom()), random_pins());
    endtask

    task automatic push_write(logic [2:0] sel, logic [15:0] data);
        push_word(OP_WRITE, sel, data, random_pins());
    endtask

    // Driver: a word is taken at an edge where cmd_valid is high and cmd_stall
    // is low. The accepted word is fed to the model right there, so the queue
    // of owed responses stays in acceptance order. A stalled word is held.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                rsp_expected_q.push_back(exti_execute(cmd));
            if (!cmd_valid || !cmd_stall)
            begin
                if (cmd_backlog_q.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    cmd       <= cmd_backlog_q.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted response word and stalls the block now
    // and then, outside the quiet window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected_q.size() == 0)
                begin
                    $error("unexpected response word %h", rsp);
                    mismatches++;
                end
                else
                begin
                    rsp_want = rsp_expected_q.pop_front();
                    if (rsp.read_data !== rsp_want.read_data)
                    begin
                        $error("read_data: expected %h, got %h",
                               rsp_want.read_data, rsp.read_data);
                        mismatches++;
                    end
                    if (rsp.pending_lines !== rsp_want.pending_lines)
                    begin
                        $error("pending_lines: expected %h, got %h",
                               rsp_want.pending_lines, rsp.pending_lines);
                        mismatches++;
                    end
                    if (rsp.irq_lines !== rsp_want.irq_lines)
                    begin
                        $error("irq_lines: expected %h, got %h",
                               rsp_want.irq_lines, rsp.irq_lines);
                        mismatches++;
                    end
                end
            end
            rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            silent_cycles <= 0;
        else
            silent_cycles <= silent_cycles + 1;
        if (silent_cycles >= STALL_LIMIT)
        begin
            $display("external_interrupt_edge_controller_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] pins;
        int          pick;
        logic [2:0]  sel;
        logic [15:0] data;

        mask_bits    = '0;
        rise_en_bits = '0;
        fall_en_bits = '0;
        pend_bits    = '0;
        last_level   = '0;
        for (int i = 0; i < MAX_LINES; i++)
            line_port[i] = '0;

        // Directed part. Every line unmasked, rising edges everywhere, falling
        // edges on odd lines. Line 3 is pointed at a port that does not exist,
        // which must read back as written and hold the line low.
        push_write(REG_MASK, 16'hFFFF);
        push_write(REG_RISE, 16'hFFFF);
        push_write(REG_FALL, 16'hAAAA);
        push_write(REG_GROUP0, 16'hF321);
        push_write(REG_GROUP0 + 3'd3, 16'h3210);
        push_read(REG_GROUP0);
        push_read(REG_GROUP0 + 3'd3);
        push_tick(64'h0);
        push_tick({64{1'b1}});
        push_read(REG_PEND);
        // Falling edges on lines that are already pending keep them set.
        push_tick(64'h0);
        push_write(REG_PEND, 16'hFFFF);
        push_tick({64{1'b1}});
        // A partial clear leaves the upper flags pending.
        push_write(REG_PEND, 16'h00FF);
        push_write(REG_RISE, 16'h0000);
        push_tick(64'h0);
        push_word(OP_NONE, 3'd7, 16'hFFFF, {64{1'b1}});
        push_write(REG_MASK, 16'h0000);
        push_read(REG_MASK);
        push_read(REG_RISE);
        push_read(REG_FALL);
        push_write(REG_GROUP0 + 3'd1, 16'hFFFF);
        push_write(REG_GROUP0 + 3'd2, 16'h4567);
        push_read(REG_GROUP0 + 3'd1);
        push_read(REG_GROUP0 + 3'd2);

        // Random part. Ticks dominate, and most of them flip only a few pins so
        // that edges stay sparse and pending flags come and go with the clears.
        pins = random_pins();
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                if ($urandom_range(0, 3) == 0)
                    pins = random_pins();
                else
                    pins = pins ^ (random_pins() & random_pins() & random_pins());
                push_tick(pins);
            end
            else if (pick < 70)
            begin
                push_read(3'($urandom_range(0, 7)));
            end
            else if (pick < 95)
            begin
                sel = 3'($urandom_range(0, 7));
                if (sel >= REG_GROUP0)
                    data = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : random_group();
                else if (sel != REG_PEND && $urandom_range(0, 3) == 0)
                    data = 16'hFFFF;
                else
                    data = 16'($urandom());
                push_write(sel, data);
            end
            else
            begin
                push_word(OP_NONE, 3'($urandom_range(0, 7)), 16'($urandom()),
                          random_pins());
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog to go out and for every owed response to come
        // back, then give the command and response registers room to show stray words.
        while (cmd_backlog_q.size() != 0 || cmd_valid || rsp_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("external_interrupt_edge_controller_unit: match");
        else
            $display("external_interrupt_edge_controller_unit: mismatch");
        $finish;
    end

endmodule
